/* src/mipbox_pkg.sv */
// mipbox_pkg: shared constants, register codes and tint table for the mip box downsampler
// no dependencies; imported by the top level and the port checker
`timescale 1ns / 1ps

package mipbox_pkg;

    // source geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int LINE_AW      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

    // field widths
    localparam int PIX_W   = 8;
    localparam int PAIR_W  = PIX_W + 1;
    localparam int SUM_W   = PIX_W + 2;
    localparam int LANES   = 3;
    localparam int DIM_W   = 11;
    localparam int LEVEL_W = 4;
    localparam int CFG_IDX_W = 2;
    // width-side compares need room for both the register and MAX_WIDTH
    localparam int CMP_W   = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

    // tint, unsigned 1.16 fixed point
    localparam int TINT_W  = 17;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = PIX_W + TINT_W;
    localparam int TINT_LAST = 6;

    localparam logic [TINT_W-1:0] TINT_100 = 17'd65536;
    localparam logic [TINT_W-1:0] TINT_085 = 17'd55706;
    localparam logic [TINT_W-1:0] TINT_080 = 17'd52429;
    localparam logic [TINT_W-1:0] TINT_070 = 17'd45876;
    localparam logic [TINT_W-1:0] TINT_055 = 17'd36045;
    localparam logic [TINT_W-1:0] TINT_045 = 17'd29492;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_MAX      = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_LEVEL_NUMBER  = 2'd2
    } cfg_index_t;

    typedef logic [LANES-1:0][TINT_W-1:0] tint_row_t;

    // lane 0 red, lane 1 green, lane 2 blue
    function automatic tint_row_t tint_row(input logic [2:0] sel);
        tint_row_t row;
        case (sel)
            3'd0:    row = {TINT_100, TINT_100, TINT_100};
            3'd1:    row = {TINT_070, TINT_070, TINT_100};
            3'd2:    row = {TINT_070, TINT_100, TINT_070};
            3'd3:    row = {TINT_100, TINT_080, TINT_070};
            3'd4:    row = {TINT_045, TINT_085, TINT_100};
            3'd5:    row = {TINT_100, TINT_055, TINT_085};
            default: row = {TINT_100, TINT_100, TINT_045};
        endcase
        return row;
    endfunction

endpackage

/* src/mipbox_ram.sv */
// mipbox_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mipbox_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/mip_level_box_downsampler_unit.sv */
// mip level box downsampler: an input item is registered in stage 1 and then in the output register,
// one item per cycle sustained when the output side takes items
// the line store is a single-port-read ram of pair sums; its registered read sets the latency
// reset clears counters, handshake state and registers to 64 x 64, level 1
// the line store is not cleared: the even row above always writes what the odd row reads
// depends on mipbox_pkg and mipbox_ram
`timescale 1ns / 1ps

module mip_level_box_downsampler_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mipbox_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mipbox_pkg::DIM_W-1:0]         cfg_data,
    // source pixel items
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mipbox_pkg::PIX_W-1:0]         red_in,
    input  logic [mipbox_pkg::PIX_W-1:0]         green_in,
    input  logic [mipbox_pkg::PIX_W-1:0]         blue_in,
    // output pixel items
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mipbox_pkg::PIX_W-1:0]         red_out,
    output logic [mipbox_pkg::PIX_W-1:0]         green_out,
    output logic [mipbox_pkg::PIX_W-1:0]         blue_out,
    output logic [mipbox_pkg::PIX_W-1:0]         alpha_out,
    output logic                                 last_pixel
);

    import mipbox_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    // position in the source level
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // even column pixel waiting for its partner
    logic [LANES-1:0][PIX_W-1:0] hold_reg;

    // stage 1: waits for the line store read
    logic                         s1_valid_reg, s1_valid_next;
    logic [LANES-1:0][PAIR_W-1:0] s1_pair_reg;
    logic                         s1_h1_reg;
    logic                         s1_last_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [LANES-1:0][PIX_W-1:0] out_pix_reg;
    logic                        out_last_reg;

    // effective geometry
    logic [CMP_W-1:0] w_eff, out_w, two_out_w, out_w_m1;
    logic [DIM_W-1:0] h_eff, out_h, two_out_h, out_h_m1;
    logic             w1, h1;

    // per item decode
    logic                         accept, s1_adv;
    logic [LANES-1:0][PIX_W-1:0]  pix;
    logic [LANES-1:0][PAIR_W-1:0] pair;
    logic [CMP_W-1:0]             col_ext, col_inc, idx_ext;
    logic [DIM_W-1:0]             row_ext, row_inc, row_half;
    logic                         col_ok, row_ok, pair_done, hold_load;
    logic                         line_wr, line_rd, block;
    logic                         last_now, col_wrap, row_wrap;
    logic [LINE_AW-1:0]           idx;

    // line store
    logic [LANES*PAIR_W-1:0] line_rd_data;
    logic [LANES-1:0][PAIR_W-1:0] line_pair;

    // stage 1 datapath
    tint_row_t                   tint;
    logic [2:0]                  tint_sel;
    logic [LANES-1:0][SUM_W-1:0] box_sum;
    logic [LANES-1:0][PROD_W-1:0] prod;
    logic [LANES-1:0][PIX_W-1:0] tinted;

    //------------------------------------------------------------------
    // configuration port, always ready and unchecked; the user must make writes arrive only while idle
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        level_next  = level_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  width_next  = cfg_data;
                REG_SOURCE_HEIGHT: height_next = cfg_data;
                REG_LEVEL_NUMBER:  level_next  = cfg_data[LEVEL_W-1:0];
                default:           ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // effective dimensions: zero counts as one, oversize saturates
    //------------------------------------------------------------------
    always_comb
    begin
        if (width_reg == '0)
            w_eff = CMP_W'(1);
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = CMP_W'(width_reg);

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(HEIGHT_LIMIT))
            h_eff = DIM_W'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    assign w1 = (w_eff == CMP_W'(1));
    assign h1 = (h_eff == DIM_W'(1));

    // a single column or row stands for two, so the output is at least one wide
    assign out_w     = w1 ? CMP_W'(1) : (w_eff >> 1);
    assign out_h     = h1 ? DIM_W'(1) : (h_eff >> 1);
    assign two_out_w = out_w << 1;
    assign two_out_h = out_h << 1;
    assign out_w_m1  = out_w - CMP_W'(1);
    assign out_h_m1  = out_h - DIM_W'(1);

    //------------------------------------------------------------------
    // handshake: stage 1 moves when the output register is free or taken
    //------------------------------------------------------------------
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign pix[0] = red_in;
    assign pix[1] = green_in;
    assign pix[2] = blue_in;

    //------------------------------------------------------------------
    // horizontal pairing
    //------------------------------------------------------------------
    assign col_ext = CMP_W'(col_reg);
    assign row_ext = DIM_W'(row_reg);

    // an odd last column falls outside two_out_w and is dropped
    assign col_ok    = col_ext < two_out_w;
    assign pair_done = w1 || (col_ok && col_reg[0]);
    assign hold_load = !w1 && col_ok && !col_reg[0];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (w1)
                pair[k] = {pix[k], 1'b0};
            else
                pair[k] = PAIR_W'(hold_reg[k]) + PAIR_W'(pix[k]);
        end
    end

    assign idx_ext = w1 ? '0 : (col_ext >> 1);
    assign idx     = idx_ext[LINE_AW-1:0];

    //------------------------------------------------------------------
    // vertical pairing through the line store
    // even rows write their pair sums, odd rows read them back; a write and
    // the read of the same entry are at least one item apart, and the ram
    // shows a write to a read issued on the next edge, so no forwarding
    //------------------------------------------------------------------
    assign row_ok  = row_ext < two_out_h;
    assign line_wr = accept && pair_done && !h1 && row_ok && !row_reg[0];
    assign line_rd = accept && pair_done && !h1 && row_ok && row_reg[0];
    assign block   = accept && pair_done && (h1 || (row_ok && row_reg[0]));

    assign row_half = h1 ? '0 : (row_ext >> 1);
    assign last_now = (idx_ext == out_w_m1) && (row_half == out_h_m1);

    mipbox_ram #(
        .WIDTH (LANES * PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (idx),
        .wr_data (pair),
        .rd_en   (line_rd),
        .rd_addr (idx),
        .rd_data (line_rd_data)
    );

    //------------------------------------------------------------------
    // raster position
    //------------------------------------------------------------------
    assign col_inc  = col_ext + CMP_W'(1);
    assign row_inc  = row_ext + DIM_W'(1);
    assign col_wrap = col_inc >= w_eff;
    assign row_wrap = row_inc >= h_eff;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_valid && (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT))
        begin
            // new dimensions restart the level
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    //------------------------------------------------------------------
    // stage 1: box sum, divide by four, tint, saturate
    //------------------------------------------------------------------
    assign line_pair = line_rd_data;
    assign tint_sel  = (level_reg > LEVEL_W'(TINT_LAST)) ? 3'(TINT_LAST) : level_reg[2:0];
    assign tint      = tint_row(tint_sel);

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (s1_h1_reg)
                box_sum[k] = {s1_pair_reg[k], 1'b0};
            else
                box_sum[k] = SUM_W'(line_pair[k]) + SUM_W'(s1_pair_reg[k]);
            prod[k] = PROD_W'(box_sum[k][SUM_W-1:2]) * PROD_W'(tint[k]);
            if (prod[k][PROD_W-1:FRAC_W] > (PROD_W - FRAC_W)'(PIX_MAX))
                tinted[k] = PIX_MAX;
            else
                tinted[k] = prod[k][FRAC_W+PIX_W-1:FRAC_W];
        end
    end

    assign s1_valid_next  = block ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

    //------------------------------------------------------------------
    // control registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(64);
            height_reg    <= DIM_W'(64);
            level_reg     <= LEVEL_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg      <= '0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            level_reg     <= level_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept && hold_load)
            begin
                hold_reg <= pix;
            end
        end
    end

    //------------------------------------------------------------------
    // payload registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (block)
        begin
            s1_pair_reg <= pair;
            s1_h1_reg   <= h1;
            s1_last_reg <= last_now;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_pix_reg  <= tinted;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = out_pix_reg[0];
    assign green_out  = out_pix_reg[1];
    assign blue_out   = out_pix_reg[2];
    assign alpha_out  = ALPHA_OPAQUE;
    assign last_pixel = out_last_reg;

endmodule

/* src/mipbox_checker.sv */
// mipbox_checker: port-level assertions for the mip level box downsampler, bound to the top level
// depends on mipbox_pkg and mip_level_box_downsampler_unit
`timescale 1ns / 1ps

module mipbox_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [mipbox_pkg::PIX_W-1:0]     red_out,
    input logic [mipbox_pkg::PIX_W-1:0]     green_out,
    input logic [mipbox_pkg::PIX_W-1:0]     blue_out,
    input logic [mipbox_pkg::PIX_W-1:0]     alpha_out,
    input logic                             last_pixel
);

    import mipbox_pkg::*;

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(last_pixel))
        else $error("output item changed while stalled");

    // alpha is opaque on every item
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha_out == ALPHA_OPAQUE)
        else $error("alpha not opaque");

    // input back-pressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // a fresh output item follows an accepted input item through stage 1 and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output item without matching input item");

endmodule

bind mip_level_box_downsampler_unit mipbox_checker u_mipbox_checker (.*);

/* dv/testbench.sv */
// testbench for mip_level_box_downsampler_unit: streams source pixels through a 2x2 box
// reduction and checks every output item against an in-bench prediction of the next level
// depends on mipbox_pkg and the unit under test
`timescale 1ns / 1ps

module testbench;

    import mipbox_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int SETTLE_CYCLES = 8;     // pipeline is two deep, leave margin
    localparam int HOLD_CYCLES   = 400;   // long output stall, block must back up
    localparam int RANDOM_ITEMS  = 200;
    localparam int LEVEL_CAP     = 80;    // most items queued for one random level
    localparam int WIDE_ITEMS    = 256;
    localparam int TALL_ITEMS    = 192;

    // register index past the end of the map, the unit must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // tint factors, unsigned 1.16
    localparam int unsigned Q16_ONE  = 65536;
    localparam int unsigned Q16_0P85 = 55706;
    localparam int unsigned Q16_0P80 = 52429;
    localparam int unsigned Q16_0P70 = 45876;
    localparam int unsigned Q16_0P55 = 36045;
    localparam int unsigned Q16_0P45 = 29492;
    localparam logic [7:0]  OPAQUE   = 8'hFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } src_pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } mip_pixel_t;

    // three 9 bit horizontal pair sums, lane 0 red, 1 green, 2 blue
    typedef logic [2:0][8:0] pair_sums_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_MOSTLY
    } stall_mode_t;

    // dut ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [7:0]           red_in    = '0;
    logic [7:0]           green_in  = '0;
    logic [7:0]           blue_in   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           red_out;
    logic [7:0]           green_out;
    logic [7:0]           blue_out;
    logic [7:0]           alpha_out;
    logic                 last_pixel;

    // source pixels waiting for the driver, and predicted output pixels in order
    src_pixel_t pending_pixels[$];
    mip_pixel_t expected_pixels[$];
    int         mismatches = 0;

    // predicted register and position state of the unit
    logic [DIM_W-1:0]   width_reg  = 11'd64;
    logic [DIM_W-1:0]   height_reg = 11'd64;
    logic [LEVEL_W-1:0] level_reg  = 4'd1;
    pair_sums_t         line_sums [LINE_DEPTH];
    pair_sums_t         held_pair  = '0;
    int unsigned        col_pos    = 0;
    int unsigned        row_pos    = 0;

    // sender burst state, receiver stall state
    int          burst_left = 1;
    int          idle_left  = 0;
    int          ready_tick = 0;
    stall_mode_t ready_mode = READY_ALWAYS;
    int          hold_left  = 0;
    int          hold_off_requests = 0;
    int          hold_off_served   = 0;

    mip_level_box_downsampler_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .last_pixel (last_pixel)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // tint per level entry and lane
    function automatic int unsigned tint_factor(input int unsigned sel, input int unsigned lane);
        int unsigned row [3];
        case (sel)
            0:       row = '{Q16_ONE,  Q16_ONE,  Q16_ONE};
            1:       row = '{Q16_ONE,  Q16_0P70, Q16_0P70};
            2:       row = '{Q16_0P70, Q16_ONE,  Q16_0P70};
            3:       row = '{Q16_0P70, Q16_0P80, Q16_ONE};
            4:       row = '{Q16_ONE,  Q16_0P85, Q16_0P45};
            5:       row = '{Q16_0P85, Q16_0P55, Q16_ONE};
            default: row = '{Q16_0P45, Q16_ONE,  Q16_ONE};
        endcase
        return row[lane];
    endfunction

    // advance the predicted unit by one source pixel; returns 1 when a
    // finished 2x2 block yields an output pixel
    function automatic bit downsample_step(input src_pixel_t px, output mip_pixel_t res);
        int unsigned w, h, out_w, out_h, c, r, idx, tsel, s, v;
        int unsigned chan [3];
        int unsigned scaled [3];
        pair_sums_t  pair, above;
        bit          pair_done, block_done;
        // zero counts as one, oversize saturates
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
        out_w = (w / 2 != 0) ? w / 2 : 1;
        out_h = (h / 2 != 0) ? h / 2 : 1;
        c = col_pos;
        r = row_pos;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        pair = '0;
        above = '0;
        idx = 0;
        pair_done = 1'b0;
        block_done = 1'b0;
        res = '0;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;

        // horizontal pair; a single column pairs with itself, odd last column is dropped
        if (w == 1) begin
            for (int k = 0; k < 3; k++) pair[k] = 9'(2 * chan[k]);
            pair_done = 1'b1;
        end else if (c < 2 * out_w) begin
            if (c % 2 == 0) begin
                for (int k = 0; k < 3; k++) held_pair[k] = 9'(chan[k]);
            end else begin
                for (int k = 0; k < 3; k++) pair[k] = 9'(held_pair[k] + chan[k]);
                pair_done = 1'b1;
                idx = c / 2;
            end
        end

        // vertical combine; a single row counts twice, odd last row is dropped
        if (pair_done && idx < LINE_DEPTH) begin
            if (h == 1) begin
                block_done = 1'b1;
            end else if (r < 2 * out_h) begin
                if (r % 2 == 0) begin
                    line_sums[idx] = pair;
                end else begin
                    above = line_sums[idx];
                    block_done = 1'b1;
                end
            end
            if (block_done) begin
                tsel = (level_reg > 6) ? 6 : level_reg;
                for (int k = 0; k < 3; k++) begin
                    s = (h == 1) ? 2 * pair[k] : above[k] + pair[k];
                    v = ((s >> 2) * tint_factor(tsel, k)) >> 16;
                    scaled[k] = (v > 255) ? 255 : v;
                end
                res.red   = 8'(scaled[0]);
                res.green = 8'(scaled[1]);
                res.blue  = 8'(scaled[2]);
                res.alpha = OPAQUE;
                res.last  = (idx == out_w - 1) && (((h == 1) ? 0 : r / 2) == out_h - 1);
            end
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
        return block_done;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // sender: bursts of random length separated by random idle gaps;
    // a held item is only replaced after the handshake completes
    always @(posedge clk) begin : pixel_driver
        src_pixel_t next_px;
        if (rst_n && (!in_valid || in_ready)) begin
            if (idle_left > 0) begin
                idle_left--;
                in_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                next_px = pending_pixels.pop_front();
                in_valid <= 1'b1;
                red_in   <= next_px.red;
                green_in <= next_px.green;
                blue_in  <= next_px.blue;
                burst_left--;
                if (burst_left <= 0) begin
                    case ($urandom_range(0, 9))
                        // long unbroken stretch
                        0: begin
                            burst_left = $urandom_range(100, 300);
                            idle_left  = 0;
                        end
                        // short bursts with long gaps
                        1, 2: begin
                            burst_left = $urandom_range(1, 4);
                            idle_left  = $urandom_range(5, 20);
                        end
                        default: begin
                            burst_left = $urandom_range(1, 24);
                            idle_left  = $urandom_range(0, 6);
                        end
                    endcase
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern is redrawn periodically from ready_tick; a requested hold-off
    // keeps ready low for a long count regardless of the pattern
    always @(posedge clk) begin : output_sink
        ready_tick++;
        if (ready_tick % 97 == 0) ready_mode = stall_mode_t'($urandom_range(0, 3));
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_off_served != hold_off_requests) begin
            hold_off_served++;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS:      out_ready <= 1'b1;
                READY_COIN:        out_ready <= 1'($urandom_range(0, 1));
                READY_ONE_IN_FOUR: out_ready <= (ready_tick % 4 == 0);
                default:           out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // register writes update the prediction, accepted pixels produce
    // expectations, accepted output items are checked against the oldest one
    always @(posedge clk) begin : scoreboard
        src_pixel_t px;
        mip_pixel_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SOURCE_WIDTH: begin
                        width_reg = cfg_data;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    REG_SOURCE_HEIGHT: begin
                        height_reg = cfg_data;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    REG_LEVEL_NUMBER: level_reg = cfg_data[LEVEL_W-1:0];
                    default: ;    // unmapped index, no effect
                endcase
            end
            if (in_valid && in_ready) begin
                px.red   = red_in;
                px.green = green_in;
                px.blue  = blue_in;
                if (downsample_step(px, want)) expected_pixels = {expected_pixels, want};
            end
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display({"%0t: output item with none expected, expected nothing, ",
                              "actual %0d %0d %0d %0d %0d"},
                             $time, red_out, green_out, blue_out, alpha_out, last_pixel);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red_out",    want.red,   red_out);
                    check_field("green_out",  want.green, green_out);
                    check_field("blue_out",   want.blue,  blue_out);
                    check_field("alpha_out",  want.alpha, alpha_out);
                    check_field("last_pixel", 8'(want.last), 8'(last_pixel));
                end
            end
        end
    end

    // status is sampled on the falling edge, clear of all rising-edge updates
    task automatic wait_drained;
        do @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
        // items that yield no output may still be in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // both dimensions restart the level; upper data bits of the level write are junk
    task automatic configure(input int w, input int h, input int lvl);
        logic [6:0] junk;
        junk = 7'($urandom_range(0, 127));
        write_register(REG_SOURCE_WIDTH, w[DIM_W-1:0]);
        write_register(REG_SOURCE_HEIGHT, h[DIM_W-1:0]);
        write_register(REG_LEVEL_NUMBER, {junk, lvl[LEVEL_W-1:0]});
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        src_pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pending_pixels = {pending_pixels, px};
    endtask

    // channel values lean toward the extremes
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_random_pixels(input int count);
        repeat (count) queue_pixel(random_channel(), random_channel(), random_channel());
    endtask

    initial begin : stimulus
        int w, h, lvl, eff_w, eff_h, count, random_items;
        int cur_w, cur_h;
        random_items = 0;
        cur_w = 64;
        cur_h = 64;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry 64 x 64 at level 1: two full source rows
        queue_random_pixels(2 * 64);
        wait_drained();

        // 3 x 3 at level 0: odd last column and odd last row are dropped
        configure(3, 3, 0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h07, 8'h80, 8'h7F);
        queue_pixel(8'h55, 8'hAA, 8'h01);
        queue_pixel(8'hFE, 8'h00, 8'hFF);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        wait_drained();

        // highest tint entry, all white
        configure(2, 2, 6);
        repeat (4) queue_pixel(8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        // single column, level above the table clamps to its last entry
        configure(1, 2, 7);
        queue_pixel(8'hFF, 8'h00, 8'h80);
        queue_pixel(8'h01, 8'hFE, 8'h7F);
        wait_drained();

        // single row, largest level number
        configure(2, 1, 15);
        queue_pixel(8'hC3, 8'h3C, 8'hFF);
        queue_pixel(8'h3C, 8'hC3, 8'h00);
        wait_drained();

        // zero dimensions count as one; unmapped index write is ignored
        configure(0, 0, 3);
        write_register(REG_SPARE, 11'h7FF);
        queue_pixel(8'h9A, 8'h65, 8'hFF);
        wait_drained();

        // dimension write in the middle of a level restarts it
        configure(2, 2, 3);
        queue_pixel(8'h12, 8'h34, 8'h56);
        queue_pixel(8'h78, 8'h9A, 8'hBC);
        wait_drained();
        write_register(REG_SOURCE_WIDTH, 11'd2);
        queue_pixel(8'hFF, 8'h00, 8'h10);
        queue_pixel(8'h00, 8'hFF, 8'h20);
        queue_pixel(8'h80, 8'h80, 8'h30);
        queue_pixel(8'h7F, 8'h7F, 8'h40);
        wait_drained();
        cur_w = 2;
        cur_h = 2;

        // random geometries, mostly small, complete levels plus stray tails
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = $urandom_range(10, 40);
                default: w = $urandom_range(1, 9);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = $urandom_range(10, 40);
                default: h = $urandom_range(1, 9);
            endcase
            lvl = $urandom_range(0, 15);
            case ($urandom_range(0, 3))
                // level only, position carries on
                0: write_register(REG_LEVEL_NUMBER, {4'($urandom_range(0, 15)),
                                                     3'($urandom_range(0, 7)),
                                                     lvl[LEVEL_W-1:0]});
                1: begin
                    write_register(REG_SPARE, 11'($urandom_range(0, 2047)));
                    configure(w, h, lvl);
                    cur_w = w;
                    cur_h = h;
                end
                default: begin
                    configure(w, h, lvl);
                    cur_w = w;
                    cur_h = h;
                end
            endcase
            eff_w = (cur_w == 0) ? 1 : cur_w;
            eff_h = (cur_h == 0) ? 1 : cur_h;
            count = eff_w * eff_h * $urandom_range(1, 2) + $urandom_range(0, eff_w);
            if (count > LEVEL_CAP) count = LEVEL_CAP;
            queue_random_pixels(count);
            random_items += count;
            wait_drained();
        end

        // start of the widest level: oversize width saturates, zero height counts
        // as one; the receiver holds off meanwhile so the unit backs up its input
        configure(2047, 0, 4);
        queue_random_pixels(WIDE_ITEMS);
        hold_off_requests <= hold_off_requests + 1;
        wait_drained();

        // top rows of the tallest level: single column, oversize height saturates
        configure(0, 1500, 5);
        queue_random_pixels(TALL_ITEMS);
        wait_drained();

        if (mismatches == 0)
            $display("mip_level_box_downsampler_unit test passed");
        else
            $display("mip_level_box_downsampler_unit test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("mip_level_box_downsampler_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
src/mipbox_pkg.sv
src/mipbox_ram.sv
src/mip_level_box_downsampler_unit.sv
src/mipbox_checker.sv
dv/testbench.sv
